/* rtl/pecv_pkg.sv */
`default_nettype none

package pecv_pkg;

   // Three spatial axes throughout.
   localparam int AXES = 3;

   localparam int POS_W   = 32;  // Q16.16 coordinate
   localparam int MAG_W   = 33;  // magnitude of a coordinate difference
   localparam int ADH_W   = 32;  // adhesion term, Q16.16
   localparam int REST_W  = 32;  // scaled radius sum, Q16.16
   localparam int RAD_W   = 66;  // radicand of both square roots
   localparam int NORM_W  = 33;  // root of a 66-bit radicand
   localparam int STIFF_W = 32;  // stiffness, root of a 64-bit product
   localparam int WIDE_W  = 49;  // magnitude before saturation
   localparam int STR_W   = 48;  // clipped spring strength
   localparam int QUO_W   = 17;  // unit vector component, at most one in Q1.16
   localparam int FACT_W  = 16;  // rest factor, Q0.16

   localparam logic [STR_W-1:0]  STR_CLIP          = 48'h8000_0000_0000;
   localparam logic [FACT_W-1:0] REST_FACTOR_RESET = 16'd62415;

   typedef enum logic {
      CSR_REST_MODE   = 1'b0,
      CSR_REST_FACTOR = 1'b1
   } csr_index_type;

   // Carried alongside the displacement norm root.
   typedef struct packed {
      logic [AXES-1:0][MAG_W-1:0] mag;
      logic [REST_W-1:0]          rest;
   } sq_side_type;

   // Carried alongside the unit vector division.
   typedef struct packed {
      logic [STR_W-1:0]            strength;
      logic                        dneg;
      logic                        nonzero;
      logic [AXES-1:0]             neg;
      logic [AXES-1:0][WIDE_W-1:0] plain;
   } div_side_type;

   typedef struct packed {
      logic [POS_W-1:0] value;
      logic             clip;
   } sat_type;

   // Signed saturation of a sign and magnitude to the 32-bit range.
   function automatic sat_type saturate(input logic neg, input logic [WIDE_W-1:0] mag);
      sat_type res;
      if (neg) begin
         res.clip  = mag > WIDE_W'(33'h0_8000_0000);
         res.value = res.clip ? 32'h8000_0000 : (32'd0 - mag[POS_W-1:0]);
      end else begin
         res.clip  = mag > WIDE_W'(32'h7FFF_FFFF);
         res.value = res.clip ? 32'h7FFF_FFFF : mag[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/pecv_isqrt.sv */
`default_nettype none

// Pipelined restoring square root, one result bit per stage.
module pecv_isqrt
   import pecv_pkg::*;
#(
   parameter int RAD_BITS  = 66,
   parameter int SIDE_BITS = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     enable,
   input  wire logic                     in_valid,
   input  wire logic [RAD_BITS-1:0]      in_radicand,
   input  wire logic [SIDE_BITS-1:0]     in_side,
   output logic                          out_valid,
   output logic [RAD_BITS/2-1:0]         out_root,
   output logic [SIDE_BITS-1:0]          out_side
);

   localparam int ROOT_BITS = RAD_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 2;

   logic [ROOT_BITS-1:0] valid_ff;
   logic [ROOT_BITS-1:0] valid_in;
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [SIDE_BITS-1:0] side_ff [ROOT_BITS];
   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS-1];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS-1];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic [RAD_BITS-1:0]  rad_cur;
      logic [REM_BITS-1:0]  rem_cur;
      logic [ROOT_BITS-1:0] root_cur;
      logic [SIDE_BITS-1:0] side_cur;
      logic                 valid_cur;
      logic [REM_BITS-1:0]  rem_sh;
      logic [REM_BITS-1:0]  trial;
      logic                 ge;
      logic [ROOT_BITS-1:0] root_in;

      if (k == 0) begin : g_first
         assign rad_cur   = in_radicand;
         assign rem_cur   = '0;
         assign root_cur  = '0;
         assign side_cur  = in_side;
         assign valid_cur = in_valid;
      end else begin : g_next
         assign rad_cur   = rad_ff[k-1];
         assign rem_cur   = rem_ff[k-1];
         assign root_cur  = root_ff[k-1];
         assign side_cur  = side_ff[k-1];
         assign valid_cur = valid_ff[k-1];
      end

      // Bring down the next two radicand bits and try 4*root+1.
      assign rem_sh      = {rem_cur[REM_BITS-3:0], rad_cur[RAD_BITS-1 -: 2]};
      assign trial       = {root_cur, 2'b01};
      assign ge          = rem_sh >= trial;
      assign root_in     = {root_cur[ROOT_BITS-2:0], ge};
      assign valid_in[k] = valid_cur;

      always_ff @(posedge clock) begin
         if (enable) begin
            root_ff[k] <= root_in;
            side_ff[k] <= side_cur;
         end
      end

      if (k < ROOT_BITS - 1) begin : g_carry
         logic [RAD_BITS-1:0] rad_in;
         logic [REM_BITS-1:0] rem_in;
         assign rad_in = {rad_cur[RAD_BITS-3:0], 2'b00};
         assign rem_in = ge ? (rem_sh - trial) : rem_sh;
         always_ff @(posedge clock) begin
            if (enable) begin
               rad_ff[k] <= rad_in;
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule

`default_nettype wire

/* rtl/pecv_div.sv */
`default_nettype none

// Pipelined restoring divider over all axes with one shared divisor. Each
// dividend must not exceed the divisor; one quotient bit per stage.
module pecv_div
   import pecv_pkg::*;
#(
   parameter int DIV_BITS  = 33,
   parameter int QUO_BITS  = 17,
   parameter int SIDE_BITS = 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire logic                             in_valid,
   input  wire logic [AXES-1:0][DIV_BITS-1:0]    in_dividend,
   input  wire logic [DIV_BITS-1:0]              in_divisor,
   input  wire logic [SIDE_BITS-1:0]             in_side,
   output logic                                  out_valid,
   output logic [AXES-1:0][QUO_BITS-1:0]         out_quotient,
   output logic [SIDE_BITS-1:0]                  out_side
);

   localparam int REM_BITS = DIV_BITS + 1;

   logic [QUO_BITS-1:0]               valid_ff;
   logic [QUO_BITS-1:0]               valid_in;
   logic [AXES-1:0][QUO_BITS-1:0]     quo_ff [QUO_BITS];
   logic [SIDE_BITS-1:0]              side_ff [QUO_BITS];
   logic [AXES-1:0][DIV_BITS-1:0]     rem_ff [QUO_BITS-1];
   logic [DIV_BITS-1:0]               divisor_ff [QUO_BITS-1];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      logic [AXES-1:0][DIV_BITS-1:0] rem_cur;
      logic [AXES-1:0][QUO_BITS-1:0] quo_cur;
      logic [DIV_BITS-1:0]           div_cur;
      logic [SIDE_BITS-1:0]          side_cur;
      logic                          valid_cur;
      logic [AXES-1:0][REM_BITS-1:0] rem_sh;
      logic [AXES-1:0]               ge;
      logic [AXES-1:0][QUO_BITS-1:0] quo_in;
      logic [AXES-1:0][DIV_BITS-1:0] rem_next;

      if (k == 0) begin : g_first
         assign rem_cur   = in_dividend;
         assign quo_cur   = '0;
         assign div_cur   = in_divisor;
         assign side_cur  = in_side;
         assign valid_cur = in_valid;
      end else begin : g_next
         assign rem_cur   = rem_ff[k-1];
         assign quo_cur   = quo_ff[k-1];
         assign div_cur   = divisor_ff[k-1];
         assign side_cur  = side_ff[k-1];
         assign valid_cur = valid_ff[k-1];
      end

      for (genvar a = 0; a < AXES; a++) begin : g_lane
         logic [REM_BITS-1:0] diff;
         if (k == 0) begin : g_noshift
            assign rem_sh[a] = {1'b0, rem_cur[a]};
         end else begin : g_shift
            assign rem_sh[a] = {rem_cur[a], 1'b0};
         end
         assign diff        = rem_sh[a] - {1'b0, div_cur};
         assign ge[a]       = rem_sh[a] >= {1'b0, div_cur};
         assign rem_next[a] = ge[a] ? diff[DIV_BITS-1:0] : rem_sh[a][DIV_BITS-1:0];
         assign quo_in[a]   = {quo_cur[a][QUO_BITS-2:0], ge[a]};
      end

      assign valid_in[k] = valid_cur;

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_cur;
         end
      end

      if (k < QUO_BITS - 1) begin : g_carry
         logic [AXES-1:0][DIV_BITS-1:0] rem_in;
         logic [DIV_BITS-1:0]           divisor_in;
         assign rem_in     = rem_next;
         assign divisor_in = div_cur;
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k]     <= rem_in;
               divisor_ff[k] <= divisor_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid    = valid_ff[QUO_BITS-1];
   assign out_quotient = quo_ff[QUO_BITS-1];
   assign out_side     = side_ff[QUO_BITS-1];

endmodule

`default_nettype wire

/* rtl/pair_elastic_contact_velocity.sv */
`default_nettype none

// Velocity increment on the first cell of an attached pair, Q16.16 throughout.
// A word is accepted in every cycle in which the input is not stalled; the
// pipeline is 4 front stages (difference, adhesion products, squares, sum), a
// 33-stage square root that forms the displacement norm and the stiffness side
// by side, one stage for the rest-length difference and plain-mode products, a
// 17-stage divider that forms the unit vector, one stage for the strength
// product and the output register. A stall on the result side freezes the
// whole pipeline at once, so nothing is lost or repeated, and the input is
// stalled only in cycles where the output register holds a word not yet taken.
// The two configuration registers may be written only while the block is idle.
module pair_elastic_contact_velocity
   import pecv_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [31:0]   req_first_x,
   input  wire logic signed [31:0]   req_first_y,
   input  wire logic signed [31:0]   req_first_z,
   input  wire logic signed [31:0]   req_second_x,
   input  wire logic signed [31:0]   req_second_y,
   input  wire logic signed [31:0]   req_second_z,
   input  wire logic [30:0]          req_first_radius,
   input  wire logic [30:0]          req_second_radius,
   input  wire logic [30:0]          req_first_elastic_constant,
   input  wire logic [16:0]          req_first_affinity,
   input  wire logic [30:0]          req_second_elastic_constant,
   input  wire logic [16:0]          req_second_affinity,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [31:0]        rsp_delta_vx,
   output logic signed [31:0]        rsp_delta_vy,
   output logic signed [31:0]        rsp_delta_vz,
   output logic                      rsp_saturated,

   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_index,
   input  wire logic [15:0]          csr_write_data
);

   // Configuration registers.
   logic              rest_mode_ff;
   logic [FACT_W-1:0] rest_factor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_mode_ff   <= 1'b0;
         rest_factor_ff <= REST_FACTOR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_REST_MODE:   rest_mode_ff   <= csr_write_data[0];
            CSR_REST_FACTOR: rest_factor_ff <= csr_write_data;
         endcase
      end
   end

   // The whole pipeline moves unless the output word is held by the receiver.
   logic enable;
   logic rsp_valid_ff;
   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   // Stage 1: signed differences, adhesion products and the radius sum.
   logic [AXES-1:0][POS_W-1:0] first_pos;
   logic [AXES-1:0][POS_W-1:0] second_pos;
   assign first_pos  = {req_first_z, req_first_y, req_first_x};
   assign second_pos = {req_second_z, req_second_y, req_second_x};

   logic                       s1_valid_ff;
   logic [AXES-1:0][MAG_W-1:0] s1_diff_ff, s1_diff_in;
   logic [47:0]                s1_prod1_ff, s1_prod1_in;
   logic [47:0]                s1_prod2_ff, s1_prod2_in;
   logic [REST_W-1:0]          s1_rsum_ff, s1_rsum_in;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         s1_diff_in[a] = {second_pos[a][POS_W-1], second_pos[a]}
                       - {first_pos[a][POS_W-1], first_pos[a]};
      end
   end
   assign s1_prod1_in = 48'(req_first_elastic_constant) * 48'(req_first_affinity);
   assign s1_prod2_in = 48'(req_second_elastic_constant) * 48'(req_second_affinity);
   assign s1_rsum_in  = REST_W'(req_first_radius) + REST_W'(req_second_radius);

   // Stage 2: sign and magnitude per axis, adhesion terms.
   logic                       s2_valid_ff;
   logic [AXES-1:0]            s2_neg_ff, s2_neg_in;
   logic [AXES-1:0][MAG_W-1:0] s2_mag_ff, s2_mag_in;
   logic [ADH_W-1:0]           s2_adh1_ff, s2_adh2_ff;
   logic [REST_W-1:0]          s2_rsum_ff;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         s2_neg_in[a] = s1_diff_ff[a][MAG_W-1];
         s2_mag_in[a] = s2_neg_in[a] ? (MAG_W'(0) - s1_diff_ff[a]) : s1_diff_ff[a];
      end
   end

   // Stage 3: squares, product of the adhesion terms, rest length.
   logic                       s3_valid_ff;
   logic [AXES-1:0]            s3_neg_ff;
   logic [AXES-1:0][MAG_W-1:0] s3_mag_ff;
   logic [AXES-1:0][RAD_W-1:0] s3_sq_ff, s3_sq_in;
   logic [2*ADH_W-1:0]         s3_adhp_ff, s3_adhp_in;
   logic [REST_W-1:0]          s3_rest_ff, s3_rest_in;
   logic [47:0]                rest_prod;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         s3_sq_in[a] = RAD_W'(s2_mag_ff[a]) * RAD_W'(s2_mag_ff[a]);
      end
   end
   assign s3_adhp_in = (2*ADH_W)'(s2_adh1_ff) * (2*ADH_W)'(s2_adh2_ff);
   assign rest_prod  = 48'(s2_rsum_ff) * 48'(rest_factor_ff);
   assign s3_rest_in = rest_prod[47:16];

   // Stage 4: sum of squares ahead of the root pipelines.
   logic                       s4_valid_ff;
   logic [AXES-1:0]            s4_neg_ff;
   logic [AXES-1:0][MAG_W-1:0] s4_mag_ff;
   logic [RAD_W-1:0]           s4_sumsq_ff, s4_sumsq_in;
   logic [2*ADH_W-1:0]         s4_adhp_ff;
   logic [REST_W-1:0]          s4_rest_ff;

   assign s4_sumsq_in = s3_sq_ff[0] + s3_sq_ff[1] + s3_sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_diff_ff  <= s1_diff_in;
         s1_prod1_ff <= s1_prod1_in;
         s1_prod2_ff <= s1_prod2_in;
         s1_rsum_ff  <= s1_rsum_in;
         s2_neg_ff   <= s2_neg_in;
         s2_mag_ff   <= s2_mag_in;
         s2_adh1_ff  <= s1_prod1_ff[47:16];
         s2_adh2_ff  <= s1_prod2_ff[47:16];
         s2_rsum_ff  <= s1_rsum_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_mag_ff   <= s2_mag_ff;
         s3_sq_ff    <= s3_sq_in;
         s3_adhp_ff  <= s3_adhp_in;
         s3_rest_ff  <= s3_rest_in;
         s4_neg_ff   <= s3_neg_ff;
         s4_mag_ff   <= s3_mag_ff;
         s4_sumsq_ff <= s4_sumsq_in;
         s4_adhp_ff  <= s3_adhp_ff;
         s4_rest_ff  <= s3_rest_ff;
      end
   end

   // Displacement norm and stiffness, both roots of 66-bit radicands so that
   // they come out in the same cycle.
   sq_side_type         nq_side_in, nq_side;
   logic                nq_valid, st_valid;
   logic [NORM_W-1:0]   nq_root, st_root;
   logic [AXES-1:0]     st_neg;

   assign nq_side_in.mag  = s4_mag_ff;
   assign nq_side_in.rest = s4_rest_ff;

   pecv_isqrt #(
      .RAD_BITS  (RAD_W),
      .SIDE_BITS ($bits(sq_side_type))
   ) u_norm_sqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (s4_valid_ff),
      .in_radicand (s4_sumsq_ff),
      .in_side     (nq_side_in),
      .out_valid   (nq_valid),
      .out_root    (nq_root),
      .out_side    (nq_side)
   );

   pecv_isqrt #(
      .RAD_BITS  (RAD_W),
      .SIDE_BITS (AXES)
   ) u_stiff_sqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (s4_valid_ff),
      .in_radicand ({2'b00, s4_adhp_ff}),
      .in_side     (s4_neg_ff),
      .out_valid   (st_valid),
      .out_root    (st_root),
      .out_side    (st_neg)
   );

   // Stage B: distance from rest length and the plain-mode products.
   logic [STIFF_W-1:0] stiff;
   assign stiff = st_root[STIFF_W-1:0];

   logic                        b_valid_ff;
   logic                        b_dneg_ff, b_dneg_in;
   logic [NORM_W-1:0]           b_dmag_ff, b_dmag_in;
   logic                        b_nonzero_ff;
   logic [STIFF_W-1:0]          b_stiff_ff;
   logic [NORM_W-1:0]           b_norm_ff;
   logic [AXES-1:0]             b_neg_ff;
   logic [AXES-1:0][MAG_W-1:0]  b_mag_ff;
   logic [AXES-1:0][WIDE_W-1:0] b_plain_ff, b_plain_in;
   logic [NORM_W-1:0]           rest_ext;

   assign rest_ext  = NORM_W'(nq_side.rest);
   assign b_dneg_in = nq_root < rest_ext;
   assign b_dmag_in = b_dneg_in ? (rest_ext - nq_root) : (nq_root - rest_ext);

   always_comb begin
      logic [64:0] prod;
      for (int a = 0; a < AXES; a++) begin
         prod          = 65'(nq_side.mag[a]) * 65'(stiff);
         b_plain_in[a] = prod[64:16];
      end
   end

   // Strength of the spring, clipped; any value at the clip saturates anyway.
   logic [64:0]       str_prod;
   logic [WIDE_W-1:0] str_full;
   div_side_type      dv_side_in, dv_side;

   assign str_prod = 65'(b_dmag_ff) * 65'(b_stiff_ff);
   assign str_full = str_prod[64:16];

   assign dv_side_in.strength = (str_full > WIDE_W'(STR_CLIP)) ? STR_CLIP
                                                                : str_full[STR_W-1:0];
   assign dv_side_in.dneg     = b_dneg_ff;
   assign dv_side_in.nonzero  = b_nonzero_ff;
   assign dv_side_in.neg      = b_neg_ff;
   assign dv_side_in.plain    = b_plain_ff;

   // Unit vector: each magnitude over the norm, scaled by 2^16. A magnitude
   // never exceeds the norm, so seventeen quotient bits are enough.
   logic                        dv_valid;
   logic [AXES-1:0][QUO_W-1:0]  dv_unit;

   pecv_div #(
      .DIV_BITS  (NORM_W),
      .QUO_BITS  (QUO_W),
      .SIDE_BITS ($bits(div_side_type))
   ) u_unit_div (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (b_valid_ff),
      .in_dividend  (b_mag_ff),
      .in_divisor   (b_norm_ff),
      .in_side      (dv_side_in),
      .out_valid    (dv_valid),
      .out_quotient (dv_unit),
      .out_side     (dv_side)
   );

   // Stage C: rest-length magnitudes along the unit vector.
   logic                        c_valid_ff;
   logic [AXES-1:0][WIDE_W-1:0] c_rest_ff, c_rest_in;
   logic [AXES-1:0][WIDE_W-1:0] c_plain_ff;
   logic [AXES-1:0]             c_neg_ff;
   logic                        c_dneg_ff;
   logic                        c_nonzero_ff;

   always_comb begin
      logic [64:0] prod;
      for (int a = 0; a < AXES; a++) begin
         prod         = 65'(dv_side.strength) * 65'(dv_unit[a]);
         c_rest_in[a] = prod[64:16];
      end
   end

   // Output stage: mode selection and saturation.
   logic [AXES-1:0][POS_W-1:0] out_value_in;
   logic                       out_sat_in;

   always_comb begin
      logic              sneg;
      logic [WIDE_W-1:0] smag;
      sat_type           sres;
      out_sat_in = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         if (!rest_mode_ff) begin
            sneg = c_neg_ff[a];
            smag = c_plain_ff[a];
         end else if (!c_nonzero_ff) begin
            // Coincident cells give no push at all.
            sneg = 1'b0;
            smag = '0;
         end else begin
            sneg = c_dneg_ff ^ c_neg_ff[a];
            smag = c_rest_ff[a];
         end
         sres            = saturate(sneg, smag);
         out_value_in[a] = sres.value;
         out_sat_in      = out_sat_in | sres.clip;
      end
   end

   logic [AXES-1:0][POS_W-1:0] rsp_value_ff;
   logic                       rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff   <= nq_valid;
         c_valid_ff   <= dv_valid;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_dneg_ff    <= b_dneg_in;
         b_dmag_ff    <= b_dmag_in;
         b_nonzero_ff <= nq_root != '0;
         b_stiff_ff   <= stiff;
         b_norm_ff    <= nq_root;
         b_neg_ff     <= st_neg;
         b_mag_ff     <= nq_side.mag;
         b_plain_ff   <= b_plain_in;
         c_rest_ff    <= c_rest_in;
         c_plain_ff   <= dv_side.plain;
         c_neg_ff     <= dv_side.neg;
         c_dneg_ff    <= dv_side.dneg;
         c_nonzero_ff <= dv_side.nonzero;
         rsp_value_ff <= out_value_in;
         rsp_sat_ff   <= out_sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_delta_vx  = rsp_value_ff[0];
   assign rsp_delta_vy  = rsp_value_ff[1];
   assign rsp_delta_vz  = rsp_value_ff[2];
   assign rsp_saturated = rsp_sat_ff;

   // The two root pipelines must stay in lock step.
   a_sqrt_lockstep: assert property (@(posedge clock) disable iff (reset)
      nq_valid == st_valid)
      else $error("root pipelines out of step");

   // A magnitude never exceeds a nonzero norm, so no unit component passes one.
   // A zero norm divides by zero and its quotient is never used.
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_valid && dv_side.nonzero) |->
         (dv_unit[0] <= 17'h10000) && (dv_unit[1] <= 17'h10000)
         && (dv_unit[2] <= 17'h10000))
      else $error("unit vector component above one");

   // A clipped word carries at least one component at a range limit.
   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         (rsp_value_ff[0] == 32'h7FFF_FFFF) || (rsp_value_ff[0] == 32'h8000_0000) ||
         (rsp_value_ff[1] == 32'h7FFF_FFFF) || (rsp_value_ff[1] == 32'h8000_0000) ||
         (rsp_value_ff[2] == 32'h7FFF_FFFF) || (rsp_value_ff[2] == 32'h8000_0000))
      else $error("saturation flag without a clipped component");

   // A held output word freezes the pipeline, including the entry stage.
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(c_valid_ff) && $stable(s1_valid_ff))
      else $error("pipeline moved while output was held");

endmodule

`default_nettype wire
